@@ rtl/gcct_pkg.sv @@
// ----------------------------------------------------------------------------
// gcct_pkg: shared types and constants of the card table
// Sizes of the heap cards and of the bitmap rows, plus the operation and
// controller state codes.
// ----------------------------------------------------------------------------
package gcct_pkg;

  localparam int ADDR_W     = 48;
  localparam int IDX_W      = 12;
  localparam int NUM_CARDS  = 4096;
  localparam int CARD_BYTES = 512;
  localparam int CARD_SHIFT = $clog2(CARD_BYTES);

  // The bitmap is kept as rows of WORD_BITS dirty bits.
  localparam int WORD_BITS  = 16;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int NUM_WORDS  = NUM_CARDS / WORD_BITS;
  localparam int WORD_AW    = $clog2(NUM_WORDS);

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 112;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WORD_AW-1:0]   row_addr_t;

  typedef enum logic [1:0] {
    OP_MARK  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SCAN  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_QUERY_RD,
    ST_QUERY_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_START,
    ST_SCAN_END,
    ST_DONE
  } state_t;

  // Requests from the controller to the bitmap memory.
  typedef struct packed {
    logic      rd_en;
    row_addr_t rd_addr;
    logic      wr_en;
    row_addr_t wr_addr;
    word_t     wr_word;
    logic      clear;
  } ram_req_t;

endpackage

@@ rtl/gcct_bitmap_ram.sv @@
// ----------------------------------------------------------------------------
// gcct_bitmap_ram: dirty-bit store of the card table
// One synchronous memory of bitmap rows with a registered read, and one valid
// flop per row so that reset and clear empty the whole table at once.
// ----------------------------------------------------------------------------
module gcct_bitmap_ram (
  input  logic              clk,
  input  logic              rst,
  input  gcct_pkg::ram_req_t req,
  output gcct_pkg::word_t   rd_word
);
  import gcct_pkg::*;

  word_t                mem [NUM_WORDS];
  word_t                rd_data;
  logic                 rd_valid;
  logic [NUM_WORDS-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_word;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

  // A row that has not been written since reset or the last clear reads as
  // all clean.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      row_valid <= '0;
    end else if (req.wr_en) begin
      row_valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (req.rd_en) begin
      rd_valid <= row_valid[req.rd_addr];
    end
  end

  assign rd_word = rd_valid ? rd_data : '0;

endmodule

@@ rtl/gc_card_table.sv @@
// ----------------------------------------------------------------------------
// gc_card_table: card table for garbage-collector write barriers
// Records dirty heap cards, answers card queries and scans for dirty cards.
// ----------------------------------------------------------------------------
// Usage. Commands arrive on the s_ stream, one word per operation, with the
// operation code in s_tuser. Every command returns exactly one result word on
// the m_ stream, in order. heap_base is written through cfg_wr_en and
// cfg_wr_data while the block is idle.
//
// Flow. One operation is worked on at a time; s_tready is high only while
// the controller is idle. Clear goes straight to the result; an out-of-range
// mark reads nothing; mark reads the card's bitmap row and writes it back
// with the bit set; query reads the row and checks the bit; scan reads the
// bitmap rows of 16 cards in turn, checking each while the next is fetched,
// and if a dirty card is found computes the range start and then its end.
// The controller goes back to idle as the result is loaded into the output
// register and then takes the next command. Scan walks the rows through the
// one read port of the bitmap memory.
//
// Reset clears heap_base and marks every card clean at once through one valid
// flop per bitmap row; no clearing pass is needed. Clear also cleans all cards.
// If the receiver stalls, a finished result waits in the output register;
// the block accepts one more command meanwhile and holds its own result
// until the output register is free.
// ----------------------------------------------------------------------------
module gc_card_table (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration: heap_base.
  input  logic                              cfg_wr_en,
  input  logic [gcct_pkg::ADDR_W-1:0]       cfg_wr_data,
  // Command stream.
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // Fields from bit 0: address[47:0], card_index[59:48], zero[63:60].
  input  logic [gcct_pkg::IN_DATA_W-1:0]    s_tdata,
  // Fields from bit 0: operation[1:0].
  input  logic [1:0]                        s_tuser,
  // Result stream.
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // Fields from bit 0: dirty[0], in_range[1], found_card[13:2],
  // range_start[61:14], range_end[109:62], zero[111:110].
  output logic [gcct_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import gcct_pkg::*;

  // Index of the lowest set bit of a row; the caller checks the row is not zero.
  function automatic logic [BIT_W-1:0] lowest_set(input word_t w);
    logic [BIT_W-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = BIT_W'(i);
      end
    end
    return pos;
  endfunction

  state_t state, state_next;

  logic [ADDR_W-1:0] heap_base;
  logic [ADDR_W-1:0] diff;
  logic              borrow;
  logic [IDX_W-1:0]  idx;
  row_addr_t         ptr;
  logic              first_row;

  logic              res_dirty;
  logic              res_in;
  logic [IDX_W-1:0]  res_card;
  logic [ADDR_W-1:0] res_start;
  logic [ADDR_W-1:0] res_end;

  ram_req_t ram_req;
  word_t    rd_word;

  logic              s_fire;
  op_t               s_op;
  logic [ADDR_W-1:0] s_address;
  logic [IDX_W-1:0]  s_card_index;
  logic              out_free;

  logic [IDX_W-1:0]  mark_card;
  logic              mark_hit;
  word_t             scan_mask;
  word_t             scan_hits;
  logic              scan_found;
  logic              scan_last;
  logic              idx_in_range;

  assign s_op         = op_t'(s_tuser);
  assign s_address    = s_tdata[ADDR_W-1:0];
  assign s_card_index = s_tdata[ADDR_W+IDX_W-1:ADDR_W];
  assign s_fire       = s_tvalid && s_tready;
  assign out_free     = !m_tvalid || m_tready;

  // The mark address lands in the table when it is not below the base and
  // its card number stays below the card count.
  assign mark_card    = diff[CARD_SHIFT+IDX_W-1:CARD_SHIFT];
  assign mark_hit     = !borrow && ((diff >> CARD_SHIFT) < ADDR_W'(NUM_CARDS));
  assign idx_in_range = (32'(idx) < 32'(NUM_CARDS));

  // Bits below the start card are ignored in the first row of a scan.
  assign scan_mask  = first_row ? (~word_t'(0) << idx[BIT_W-1:0]) : ~word_t'(0);
  assign scan_hits  = rd_word & scan_mask;
  assign scan_found = |scan_hits;
  assign scan_last  = (ptr == row_addr_t'(NUM_WORDS - 1));

  gcct_bitmap_ram u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .req     (ram_req),
    .rd_word (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
    end else if (cfg_wr_en) begin
      heap_base <= cfg_wr_data;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          unique case (s_op)
            OP_MARK:  state_next = ST_MARK_RD;
            OP_QUERY: state_next = ST_QUERY_RD;
            OP_CLEAR: state_next = ST_DONE;
            OP_SCAN:  state_next = ST_SCAN_RD;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_MARK_RD:    state_next = mark_hit ? ST_MARK_WR : ST_DONE;
      ST_MARK_WR:    state_next = ST_DONE;
      ST_QUERY_RD:   state_next = ST_QUERY_CHK;
      ST_QUERY_CHK:  state_next = ST_DONE;
      ST_SCAN_RD:    state_next = idx_in_range ? ST_SCAN_CHK : ST_DONE;
      ST_SCAN_CHK: begin
        if (scan_found) begin
          state_next = ST_SCAN_START;
        end else if (scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN_START: state_next = ST_SCAN_END;
      ST_SCAN_END:   state_next = ST_DONE;
      ST_DONE:       state_next = out_free ? ST_IDLE : ST_DONE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Handshake and memory requests.
  always_comb begin
    s_tready        = 1'b0;
    ram_req         = '0;
    ram_req.rd_addr = ptr;
    ram_req.wr_addr = mark_card[IDX_W-1:BIT_W];
    ram_req.wr_word = rd_word | (word_t'(1) << mark_card[BIT_W-1:0]);
    unique case (state)
      ST_IDLE: begin
        s_tready      = 1'b1;
        ram_req.clear = s_fire && (s_op == OP_CLEAR);
      end
      ST_MARK_RD: begin
        ram_req.rd_en   = mark_hit;
        ram_req.rd_addr = mark_card[IDX_W-1:BIT_W];
      end
      ST_MARK_WR: begin
        ram_req.wr_en = 1'b1;
      end
      ST_QUERY_RD: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = idx[IDX_W-1:BIT_W];
      end
      ST_SCAN_RD: begin
        ram_req.rd_en = idx_in_range;
      end
      ST_SCAN_CHK: begin
        // Fetch the following row while this one is checked.
        ram_req.rd_en   = !scan_found && !scan_last;
        ram_req.rd_addr = ptr + row_addr_t'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Operation datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_fire) begin
          {borrow, diff} <= {1'b0, s_address} - {1'b0, heap_base};
          idx            <= s_card_index;
          ptr            <= s_card_index[IDX_W-1:BIT_W];
          first_row      <= 1'b1;
          res_dirty      <= 1'b0;
          res_in         <= 1'b0;
          res_card       <= '0;
          res_start      <= '0;
          res_end        <= '0;
        end
      end
      ST_MARK_WR: begin
        res_in <= 1'b1;
      end
      ST_QUERY_CHK: begin
        res_dirty <= idx_in_range && rd_word[idx[BIT_W-1:0]];
      end
      ST_SCAN_CHK: begin
        if (scan_found) begin
          res_dirty <= 1'b1;
          res_card  <= {ptr, lowest_set(scan_hits)};
        end else if (!scan_last) begin
          ptr       <= ptr + row_addr_t'(1);
          first_row <= 1'b0;
        end
      end
      ST_SCAN_START: begin
        res_start <= heap_base + (ADDR_W'(res_card) << CARD_SHIFT);
      end
      ST_SCAN_END: begin
        res_end <= res_start + ADDR_W'(CARD_BYTES);
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {2'b00, res_end, res_start, res_card, res_in, res_dirty};
    end
  end

endmodule
